// ----- rtl/link_rate_fallback_monitor_core_assert.svh -----
// Assertion macros shared by the monitor's RTL files.
// Both expect a signal named clock in the module that uses them; LRFM_CHECK also expects reset.
`ifndef LINK_RATE_FALLBACK_MONITOR_CORE_ASSERT_SVH
`define LINK_RATE_FALLBACK_MONITOR_CORE_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define LRFM_CHECK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Check a property on every clock edge, reset included.
`define LRFM_CHECK_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- rtl/lrfm_pkg.sv -----
`default_nettype none

package lrfm_pkg;

   // Field widths fixed by the block definition
   localparam int unsigned CNT_W = 16;
   localparam int unsigned EST_W = 17;

   // Estimate of one (1.0 in Q1.16)
   localparam logic [EST_W-1:0] EST_ONE = 17'h10000;

   // Averaging weight 0.3 in Q0.16
   localparam logic signed [15:0] WEIGHT_Q16 = 16'sd19661;

   // Rounding offset for the Q0.16 product
   localparam logic signed [33:0] ROUND_HALF = 34'sd32768;

   // Received block count that must be exceeded before fall-forward
   localparam logic [31:0] MIN_BLOCKS = 32'd2000;

   // Remainder steps after the leading quotient bit
   localparam int unsigned DIV_STEPS = 16;
   localparam logic [3:0] DIV_LAST = 4'(DIV_STEPS - 1);

   // Register indexes on the configuration port
   typedef enum logic [2:0] {
      CSR_BURST_WINDOW         = 3'd0,
      CSR_BURST_ERROR_LIMIT    = 3'd1,
      CSR_FALLBACK_WINDOW      = 3'd2,
      CSR_FALLBACK_ERROR_LIMIT = 3'd3,
      CSR_RATE_CHANGE_ENABLE   = 3'd4,
      CSR_MARGIN_LIMIT         = 3'd5
   } csr_index_type;

   // Register reset values
   localparam logic [CNT_W-1:0]        BURST_WINDOW_RST         = 16'd31;
   localparam logic [CNT_W-1:0]        BURST_ERROR_LIMIT_RST    = 16'd24;
   localparam logic [CNT_W-1:0]        FALLBACK_WINDOW_RST      = 16'd1000;
   localparam logic [CNT_W-1:0]        FALLBACK_ERROR_LIMIT_RST = 16'd100;
   localparam logic signed [15:0]      MARGIN_LIMIT_RST         = 16'sd3840;

   // Window counter status for the block being stepped
   typedef struct packed {
      logic             close;
      logic             tripped;
      logic [CNT_W-1:0] blocks;
      logic [CNT_W-1:0] errors;
   } win_stat_type;

   // Estimator status
   typedef struct packed {
      logic busy;
      logic done;
   } est_stat_type;

   // Request flags of one result item
   typedef struct packed {
      logic abort_request;
      logic fallback_request;
      logic local_ready;
      logic forward_request;
   } rsp_flags_type;

endpackage

`default_nettype wire

// ----- rtl/lrfm_if.sv -----
`default_nettype none

// Input item channel
interface lrfm_req_if;
   logic               valid;
   logic               ready;
   logic               block_fail;
   logic signed [15:0] margin;
   logic [31:0]        blocks_received;
   logic               higher_rate_ok;
   logic               far_end_ready;

   modport source (output valid, block_fail, margin, blocks_received, higher_rate_ok,
                   far_end_ready, input ready);
   modport sink (input valid, block_fail, margin, blocks_received, higher_rate_ok,
                 far_end_ready, output ready);
endinterface

// Result item channel
interface lrfm_rsp_if;
   logic        valid;
   logic        ready;
   logic        abort_request;
   logic        fallback_request;
   logic        local_ready;
   logic        forward_request;
   logic [16:0] error_estimate;

   modport source (output valid, abort_request, fallback_request, local_ready,
                   forward_request, error_estimate, input ready);
   modport sink (input valid, abort_request, fallback_request, local_ready,
                 forward_request, error_estimate, output ready);
endinterface

// Configuration write channel
interface lrfm_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  idx;
   logic [15:0] wdata;

   modport source (output valid, idx, wdata, input ready);
   modport sink (input valid, idx, wdata, output ready);
endinterface

`default_nettype wire

// ----- rtl/lrfm_window.sv -----
`default_nettype none

module lrfm_window (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          step,
   input  wire logic                          block_fail,
   input  wire logic [lrfm_pkg::CNT_W-1:0]    window,
   input  wire logic [lrfm_pkg::CNT_W-1:0]    limit,
   output lrfm_pkg::win_stat_type             stat
);

   logic [lrfm_pkg::CNT_W-1:0] blocks_ff, blocks_in;
   logic [lrfm_pkg::CNT_W-1:0] errors_ff, errors_in;
   logic                       tripped_ff;
   logic [lrfm_pkg::CNT_W-1:0] blk_inc;
   logic [lrfm_pkg::CNT_W-1:0] err_inc;
   logic                       close;

   // Count this block and check for window close
   always_comb begin
      blk_inc      = blocks_ff + 16'd1;
      err_inc      = errors_ff + 16'(block_fail);
      close        = (blk_inc >= window);
      stat.close   = close;
      stat.tripped = tripped_ff | (close & (err_inc >= limit));
      stat.blocks  = blk_inc;
      stat.errors  = err_inc;
      blocks_in    = close ? '0 : blk_inc;
      errors_in    = close ? '0 : err_inc;
   end

   // Advance counters and hold the sticky trip flag
   always_ff @(posedge clock) begin
      if (reset) begin
         blocks_ff  <= '0;
         errors_ff  <= '0;
         tripped_ff <= 1'b0;
      end else if (step) begin
         blocks_ff  <= blocks_in;
         errors_ff  <= errors_in;
         tripped_ff <= stat.tripped;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/lrfm_estimator.sv -----
`default_nettype none
`include "link_rate_fallback_monitor_core_assert.svh"

module lrfm_estimator (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       go,
   input  lrfm_pkg::win_stat_type          fb_stat,
   output lrfm_pkg::est_stat_type          est_stat,
   output logic [lrfm_pkg::EST_W-1:0]      avg
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_MUL,
      ST_ADD
   } state_type;

   state_type                  state_ff;
   logic                       done_ff;
   logic [lrfm_pkg::EST_W-1:0] avg_ff, avg_in;
   logic [lrfm_pkg::CNT_W-1:0] div_ff;
   logic [lrfm_pkg::CNT_W-1:0] rem_ff, rem_in;
   logic [lrfm_pkg::EST_W-1:0] quo_ff;
   logic [3:0]                 cnt_ff;
   logic signed [33:0]         prod_ff, prod_in;

   logic [16:0]                trial;
   logic                       fits;
   logic signed [17:0]         diff;
   logic signed [33:0]         diff_ext;
   logic signed [33:0]         weight_ext;
   logic signed [33:0]         rounded;
   logic signed [17:0]         step_q;
   logic signed [18:0]         step_ext;
   logic signed [18:0]         sum;

   // One quotient bit per cycle: shift remainder, trial subtract
   always_comb begin
      trial  = {rem_ff, 1'b0};
      fits   = (trial >= {1'b0, div_ff});
      rem_in = fits ? 16'(trial - {1'b0, div_ff}) : trial[15:0];
   end

   // Weighted difference, then round and clamp the new average
   always_comb begin
      diff       = $signed({1'b0, quo_ff}) - $signed({1'b0, avg_ff});
      diff_ext   = 34'(diff);
      weight_ext = 34'(lrfm_pkg::WEIGHT_Q16);
      prod_in    = diff_ext * weight_ext;
      rounded    = prod_ff + lrfm_pkg::ROUND_HALF;
      step_q     = rounded[33:16];
      step_ext   = 19'(step_q);
      sum        = $signed({2'b00, avg_ff}) + step_ext;
      priority if (sum < 19'sd0) begin
         avg_in = '0;
      end else if (sum > $signed({2'b00, lrfm_pkg::EST_ONE})) begin
         avg_in = lrfm_pkg::EST_ONE;
      end else begin
         avg_in = sum[16:0];
      end
   end

   // Sequence divide, multiply and update
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         done_ff  <= 1'b0;
         avg_ff   <= '0;
         cnt_ff   <= '0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (go) begin
                  div_ff <= fb_stat.blocks;
                  cnt_ff <= '0;
                  if (fb_stat.errors >= fb_stat.blocks) begin
                     rem_ff <= fb_stat.errors - fb_stat.blocks;
                     quo_ff <= 17'd1;
                  end else begin
                     rem_ff <= fb_stat.errors;
                     quo_ff <= '0;
                  end
                  state_ff <= ST_DIV;
               end
            end
            ST_DIV: begin
               rem_ff <= rem_in;
               quo_ff <= {quo_ff[15:0], fits};
               cnt_ff <= cnt_ff + 4'd1;
               if (cnt_ff == lrfm_pkg::DIV_LAST) begin
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL: begin
               prod_ff  <= prod_in;
               state_ff <= ST_ADD;
            end
            ST_ADD: begin
               avg_ff   <= avg_in;
               done_ff  <= 1'b1;
               state_ff <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign est_stat.busy = (state_ff != ST_IDLE);
   assign est_stat.done = done_ff;
   assign avg           = avg_ff;

   `LRFM_CHECK(a_rem_below_divisor, (state_ff == ST_DIV) |-> (rem_ff < div_ff), "remainder overflow")
   `LRFM_CHECK(a_avg_in_range, avg_ff <= lrfm_pkg::EST_ONE, "average above one")
   `LRFM_CHECK(a_quotient_in_range, done_ff |-> (quo_ff <= lrfm_pkg::EST_ONE), "ratio above one")
   `LRFM_CHECK_ALWAYS(a_no_done_after_reset, $past(reset) |-> !done_ff, "done right after reset")

endmodule

`default_nettype wire

// ----- rtl/link_rate_fallback_monitor_core.sv -----
// Link rate fallback monitor. Takes one item per received data block and
// answers each with one result item carrying the abort, fallback and
// fall-forward requests and the averaged block error probability (Q1.16).
// Two windowed error counters set sticky trip flags that clear only on reset.
// Items are handled one at a time. An item that does not close the fallback
// window goes to the result register once it is free or being emptied; one
// that closes it first waits for the serial divider, which finds the window's
// error ratio one quotient bit per cycle (17 bits), then for one multiply and
// one update step. A waiting result does not block the next item, but a second
// result waits until the first is taken. Write configuration only while no
// item is in progress; writes to indexes beyond the register list are ignored.
`default_nettype none
`include "link_rate_fallback_monitor_core_assert.svh"

module link_rate_fallback_monitor_core (
   input  wire logic   clock,
   input  wire logic   reset,
   lrfm_req_if.sink    req_ch,
   lrfm_rsp_if.source  rsp_ch,
   lrfm_csr_if.sink    csr_ch
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EST,
      ST_PUSH
   } state_type;

   state_type                   state_ff;
   lrfm_pkg::rsp_flags_type     pend_ff, pend_in;
   logic                        rsp_valid_ff;
   lrfm_pkg::rsp_flags_type     rsp_flags_ff;
   logic [lrfm_pkg::EST_W-1:0]  rsp_est_ff;

   logic [lrfm_pkg::CNT_W-1:0]  burst_window_ff;
   logic [lrfm_pkg::CNT_W-1:0]  burst_error_limit_ff;
   logic [lrfm_pkg::CNT_W-1:0]  fallback_window_ff;
   logic [lrfm_pkg::CNT_W-1:0]  fallback_error_limit_ff;
   logic                        rate_change_enable_ff;
   logic signed [15:0]          margin_limit_ff;

   logic                        req_take;
   logic                        est_go;
   logic                        push_go;
   logic                        local_ok;
   lrfm_pkg::win_stat_type      burst_stat;
   lrfm_pkg::win_stat_type      fb_stat;
   lrfm_pkg::est_stat_type      est_stat;
   logic [lrfm_pkg::EST_W-1:0]  est_avg;

   // Write configuration registers
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         burst_window_ff         <= lrfm_pkg::BURST_WINDOW_RST;
         burst_error_limit_ff    <= lrfm_pkg::BURST_ERROR_LIMIT_RST;
         fallback_window_ff      <= lrfm_pkg::FALLBACK_WINDOW_RST;
         fallback_error_limit_ff <= lrfm_pkg::FALLBACK_ERROR_LIMIT_RST;
         rate_change_enable_ff   <= 1'b0;
         margin_limit_ff         <= lrfm_pkg::MARGIN_LIMIT_RST;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.idx)
            lrfm_pkg::CSR_BURST_WINDOW:         burst_window_ff <= csr_ch.wdata;
            lrfm_pkg::CSR_BURST_ERROR_LIMIT:    burst_error_limit_ff <= csr_ch.wdata;
            lrfm_pkg::CSR_FALLBACK_WINDOW:      fallback_window_ff <= csr_ch.wdata;
            lrfm_pkg::CSR_FALLBACK_ERROR_LIMIT: fallback_error_limit_ff <= csr_ch.wdata;
            lrfm_pkg::CSR_RATE_CHANGE_ENABLE:   rate_change_enable_ff <= csr_ch.wdata[0];
            lrfm_pkg::CSR_MARGIN_LIMIT:         margin_limit_ff <= $signed(csr_ch.wdata);
            default: begin
            end
         endcase
      end
   end

   // Accept an item only between items
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_take     = req_ch.valid && req_ch.ready;
   assign est_go       = req_take && fb_stat.close;

   // Load the result register once it is free or being emptied
   assign push_go      = (state_ff == ST_PUSH) && (!rsp_valid_ff || rsp_ch.ready);

   lrfm_window u_burst (
      .clock      (clock),
      .reset      (reset),
      .step       (req_take),
      .block_fail (req_ch.block_fail),
      .window     (burst_window_ff),
      .limit      (burst_error_limit_ff),
      .stat       (burst_stat)
   );

   lrfm_window u_fallback (
      .clock      (clock),
      .reset      (reset),
      .step       (req_take),
      .block_fail (req_ch.block_fail),
      .window     (fallback_window_ff),
      .limit      (fallback_error_limit_ff),
      .stat       (fb_stat)
   );

   lrfm_estimator u_est (
      .clock    (clock),
      .reset    (reset),
      .go       (est_go),
      .fb_stat  (fb_stat),
      .est_stat (est_stat),
      .avg      (est_avg)
   );

   // Form the request flags of the incoming item
   always_comb begin
      local_ok = rate_change_enable_ff && (req_ch.margin > margin_limit_ff) &&
                 (req_ch.blocks_received > lrfm_pkg::MIN_BLOCKS) && req_ch.higher_rate_ok;
      pend_in.abort_request    = burst_stat.tripped;
      pend_in.fallback_request = rate_change_enable_ff & fb_stat.tripped;
      pend_in.local_ready      = local_ok;
      pend_in.forward_request  = local_ok & req_ch.far_end_ready;
   end

   // Sequence items and hold the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready && !push_go) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_take) begin
                  pend_ff  <= pend_in;
                  state_ff <= fb_stat.close ? ST_EST : ST_PUSH;
               end
            end
            ST_EST: begin
               if (est_stat.done) begin
                  state_ff <= ST_PUSH;
               end
            end
            ST_PUSH: begin
               if (push_go) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_flags_ff <= pend_ff;
                  rsp_est_ff   <= est_avg;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.abort_request    = rsp_flags_ff.abort_request;
   assign rsp_ch.fallback_request = rsp_flags_ff.fallback_request;
   assign rsp_ch.local_ready      = rsp_flags_ff.local_ready;
   assign rsp_ch.forward_request  = rsp_flags_ff.forward_request;
   assign rsp_ch.error_estimate   = rsp_est_ff;

   `LRFM_CHECK(a_done_while_waiting, est_stat.done |-> (state_ff == ST_EST), "stray estimator done")
   `LRFM_CHECK(a_est_active, (state_ff == ST_EST) |-> (est_stat.busy || est_stat.done), "estimator lost")
   `LRFM_CHECK(a_estimate_range, rsp_valid_ff |-> (rsp_est_ff <= lrfm_pkg::EST_ONE), "estimate above one")
   `LRFM_CHECK(a_forward_needs_local, rsp_valid_ff |-> (!rsp_flags_ff.forward_request || rsp_flags_ff.local_ready), "forward without local")

endmodule

`default_nettype wire

// ----- verif/lrfm_link_check.sv -----
module lrfm_link_check
   import lrfm_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic              req_ready,
   input  wire logic              req_block_fail,
   input  wire logic signed [15:0] req_margin,
   input  wire logic [31:0]       req_blocks_received,
   input  wire logic              req_higher_rate_ok,
   input  wire logic              req_far_end_ready,
   input  wire logic              rsp_valid,
   input  wire logic              rsp_ready,
   input  wire logic              rsp_abort_request,
   input  wire logic              rsp_fallback_request,
   input  wire logic              rsp_local_ready,
   input  wire logic              rsp_forward_request,
   input  wire logic [EST_W-1:0]  rsp_error_estimate,
   input  wire logic              csr_valid,
   input  wire logic              csr_ready,
   input  wire logic [2:0]        csr_idx,
   input  wire logic [15:0]       csr_wdata,
   output int                     mismatch_count,
   output int                     reports_waiting
);

   // One expected result item
   typedef struct {
      rsp_flags_type    flags;
      logic [EST_W-1:0] estimate;
   } link_report_type;

   link_report_type link_reports_q[$];
   link_report_type oldest;

   // Register copies
   logic [CNT_W-1:0]   burst_len;
   logic [CNT_W-1:0]   burst_limit;
   logic [CNT_W-1:0]   fallback_len;
   logic [CNT_W-1:0]   fallback_limit;
   logic               rate_enable;
   logic signed [15:0] margin_floor;

   // Window and estimator state
   logic [CNT_W-1:0]   burst_count;
   logic [CNT_W-1:0]   burst_err_count;
   logic               burst_trip;
   logic [CNT_W-1:0]   fb_count;
   logic [CNT_W-1:0]   fb_err_count;
   logic               fb_trip;
   logic [EST_W-1:0]   err_average;

   // Advance both windows by one block and form the report for it
   function automatic link_report_type step_windows(input logic crc,
                                                    input logic signed [15:0] margin,
                                                    input logic [31:0] received,
                                                    input logic higher,
                                                    input logic far);
      link_report_type rep;
      longint ratio;
      longint acc;
      logic near_ok;

      burst_count     = burst_count + 1'b1;
      burst_err_count = burst_err_count + crc;
      if (burst_count >= burst_len) begin
         if (burst_err_count >= burst_limit) burst_trip = 1'b1;
         burst_count     = '0;
         burst_err_count = '0;
      end

      fb_count     = fb_count + 1'b1;
      fb_err_count = fb_err_count + crc;
      if (fb_count >= fallback_len) begin
         if (fb_err_count >= fallback_limit) fb_trip = 1'b1;
         // blend the window's error ratio into the average, floor after rounding offset
         if (fb_count != '0) begin
            ratio = (longint'(fb_err_count) << 16) / longint'(fb_count);
            if (ratio > longint'(EST_ONE)) ratio = longint'(EST_ONE);
            acc = (ratio - longint'(err_average)) * longint'(WEIGHT_Q16)
                  + longint'(ROUND_HALF);
            acc = longint'(err_average) + (acc >>> 16);
            if (acc < 0) acc = 0;
            if (acc > longint'(EST_ONE)) acc = longint'(EST_ONE);
            err_average = EST_W'(acc);
         end
         fb_count     = '0;
         fb_err_count = '0;
      end

      near_ok = rate_enable && (margin > margin_floor) && (received > MIN_BLOCKS) && higher;

      rep.flags.abort_request    = burst_trip;
      rep.flags.fallback_request = rate_enable & fb_trip;
      rep.flags.local_ready      = near_ok;
      rep.flags.forward_request  = near_ok & far;
      rep.estimate               = err_average;
      return rep;
   endfunction

   // Compare one field, four-state
   task automatic check_field(input string label, input logic [EST_W-1:0] want_v,
                              input logic [EST_W-1:0] got_v);
      if (want_v !== got_v) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want_v, got_v);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         burst_len       = BURST_WINDOW_RST;
         burst_limit     = BURST_ERROR_LIMIT_RST;
         fallback_len    = FALLBACK_WINDOW_RST;
         fallback_limit  = FALLBACK_ERROR_LIMIT_RST;
         rate_enable     = 1'b0;
         margin_floor    = MARGIN_LIMIT_RST;
         burst_count     = '0;
         burst_err_count = '0;
         burst_trip      = 1'b0;
         fb_count        = '0;
         fb_err_count    = '0;
         fb_trip         = 1'b0;
         err_average     = '0;
         link_reports_q.delete();
         reports_waiting <= 0;
      end else begin
         // match a delivered result item against the oldest report
         if (rsp_valid && rsp_ready) begin
            if (link_reports_q.size() == 0) begin
               $display("%0t: unexpected result item, expected none, actual estimate %0d",
                        $time, rsp_error_estimate);
               mismatch_count++;
            end else begin
               oldest = link_reports_q.pop_front();
               check_field("abort_request", oldest.flags.abort_request, rsp_abort_request);
               check_field("fallback_request", oldest.flags.fallback_request,
                           rsp_fallback_request);
               check_field("local_ready", oldest.flags.local_ready, rsp_local_ready);
               check_field("forward_request", oldest.flags.forward_request,
                           rsp_forward_request);
               check_field("error_estimate", oldest.estimate, rsp_error_estimate);
            end
         end

         // track register writes; spare indexes drop
         if (csr_valid && csr_ready) begin
            case (csr_idx)
               CSR_BURST_WINDOW:         burst_len      = csr_wdata;
               CSR_BURST_ERROR_LIMIT:    burst_limit    = csr_wdata;
               CSR_FALLBACK_WINDOW:      fallback_len   = csr_wdata;
               CSR_FALLBACK_ERROR_LIMIT: fallback_limit = csr_wdata;
               CSR_RATE_CHANGE_ENABLE:   rate_enable    = csr_wdata[0];
               CSR_MARGIN_LIMIT:         margin_floor   = signed'(csr_wdata);
               default: ;
            endcase
         end

         // predict the accepted block
         if (req_valid && req_ready)
            link_reports_q.push_back(step_windows(req_block_fail, req_margin,
                                                  req_blocks_received, req_higher_rate_ok,
                                                  req_far_end_ready));

         reports_waiting <= link_reports_q.size();
      end
   end

endmodule

// ----- verif/tb.sv -----
module tb;
   import lrfm_pkg::*;

   localparam int HALF_PERIOD  = 6;
   localparam int RANDOM_ITEMS = 1030;
   localparam int TAIL_CYCLES  = 40;
   localparam longint RUN_LIMIT = 64'd12_000_000;

   // Indexes past the register list
   localparam logic [2:0] CSR_SPARE_LO = 3'd6;
   localparam logic [2:0] CSR_SPARE_HI = 3'd7;

   // Receiver stall patterns
   typedef enum logic [1:0] {RX_OPEN, RX_SPARSE, RX_PERIODIC, RX_HOLD} rx_mode_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;

   logic               req_valid = 1'b0;
   logic               req_crc = 1'b0;
   logic signed [15:0] req_margin = '0;
   logic [31:0]        req_count = '0;
   logic               req_higher = 1'b0;
   logic               req_far = 1'b0;
   logic               rsp_ready = 1'b0;
   logic               csr_valid = 1'b0;
   logic [2:0]         csr_idx = '0;
   logic [15:0]        csr_wdata = '0;

   rx_mode_type        rx_mode = RX_OPEN;
   int                 rx_left = 0;
   logic signed [15:0] margin_ref = MARGIN_LIMIT_RST;
   int                 mismatches;
   int                 reports_waiting;

   lrfm_req_if req_ch ();
   lrfm_rsp_if rsp_ch ();
   lrfm_csr_if csr_ch ();

   assign req_ch.valid           = req_valid;
   assign req_ch.block_fail      = req_crc;
   assign req_ch.margin          = req_margin;
   assign req_ch.blocks_received = req_count;
   assign req_ch.higher_rate_ok  = req_higher;
   assign req_ch.far_end_ready   = req_far;
   assign rsp_ch.ready           = rsp_ready;
   assign csr_ch.valid           = csr_valid;
   assign csr_ch.idx             = csr_idx;
   assign csr_ch.wdata           = csr_wdata;

   link_rate_fallback_monitor_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   lrfm_link_check link_check (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_ch.valid),
      .req_ready            (req_ch.ready),
      .req_block_fail       (req_ch.block_fail),
      .req_margin           (req_ch.margin),
      .req_blocks_received  (req_ch.blocks_received),
      .req_higher_rate_ok   (req_ch.higher_rate_ok),
      .req_far_end_ready    (req_ch.far_end_ready),
      .rsp_valid            (rsp_ch.valid),
      .rsp_ready            (rsp_ch.ready),
      .rsp_abort_request    (rsp_ch.abort_request),
      .rsp_fallback_request (rsp_ch.fallback_request),
      .rsp_local_ready      (rsp_ch.local_ready),
      .rsp_forward_request  (rsp_ch.forward_request),
      .rsp_error_estimate   (rsp_ch.error_estimate),
      .csr_valid            (csr_ch.valid),
      .csr_ready            (csr_ch.ready),
      .csr_idx              (csr_ch.idx),
      .csr_wdata            (csr_ch.wdata),
      .mismatch_count       (mismatches),
      .reports_waiting      (reports_waiting)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // Stall the receiver in stretches of changing pattern
   always @(posedge clock) begin
      if (rx_left == 0) begin
         rx_mode <= rx_mode_type'($urandom_range(0, 3));
         rx_left <= $urandom_range(16, 96);
      end else begin
         rx_left <= rx_left - 1;
      end
      case (rx_mode)
         RX_OPEN:     rsp_ready <= 1'b1;
         RX_SPARSE:   rsp_ready <= ($urandom_range(0, 3) != 0);
         RX_PERIODIC: rsp_ready <= (rx_left % 4 == 0);
         default:     rsp_ready <= (rx_left < 6);
      endcase
   end

   // Offer one block; valid stays high after acceptance
   task automatic offer_block(input logic crc, input logic signed [15:0] mg,
                              input logic [31:0] cnt, input logic hi, input logic far);
      req_valid  <= 1'b1;
      req_crc    <= crc;
      req_margin <= mg;
      req_count  <= cnt;
      req_higher <= hi;
      req_far    <= far;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   // Write one register; valid stays high after acceptance
   task automatic set_reg(input logic [2:0] idx, input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_idx   <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
   endtask

   task automatic configure(input logic [15:0] bw, input logic [15:0] bl,
                            input logic [15:0] fw, input logic [15:0] fl,
                            input logic en, input logic signed [15:0] ml);
      set_reg(CSR_BURST_WINDOW, bw);
      set_reg(CSR_BURST_ERROR_LIMIT, bl);
      set_reg(CSR_FALLBACK_WINDOW, fw);
      set_reg(CSR_FALLBACK_ERROR_LIMIT, fl);
      set_reg(CSR_RATE_CHANGE_ENABLE, {15'd0, en});
      set_reg(CSR_MARGIN_LIMIT, ml);
      csr_valid  <= 1'b0;
      margin_ref = ml;
   endtask

   // Drop valid and hold until every result item is back
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (reports_waiting != 0);
   endtask

   // Mostly short windows so they close often
   function automatic logic [15:0] pick_window();
      case ($urandom_range(0, 9))
         0:       return 16'd0;
         1:       return 16'hFFFF;
         2:       return 16'($urandom);
         3:       return 16'd1;
         default: return 16'($urandom_range(2, 40));
      endcase
   endfunction

   function automatic logic [15:0] pick_limit();
      case ($urandom_range(0, 7))
         0:       return 16'd0;
         1:       return 16'hFFFF;
         2:       return 16'($urandom);
         default: return 16'($urandom_range(1, 24));
      endcase
   endfunction

   initial begin
      int left;
      int burst;
      int gap;
      int sent;
      int n;
      int err_thr;
      int gap_style;
      int mg_wide;
      int err_levels[5];
      logic signed [15:0] mg;
      logic signed [15:0] ml;
      logic [31:0] cnt;

      err_levels = '{0, 1, 4, 8, 16};
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset settings, rate change disabled
      offer_block(1'b1, 16'sh7FFF, 32'hFFFF_FFFF, 1'b1, 1'b1);
      offer_block(1'b0, 16'sh8000, 32'd0, 1'b0, 1'b0);
      offer_block(1'b1, 16'sd3841, 32'd2001, 1'b1, 1'b1);
      settle();

      // margin and count at their thresholds, two fallback window closes
      configure(16'd3, 16'd3, 16'd4, 16'hFFFF, 1'b1, 16'sd0);
      offer_block(1'b1, 16'sd0, 32'd2001, 1'b1, 1'b1);
      offer_block(1'b1, 16'sd1, 32'd2000, 1'b1, 1'b1);
      offer_block(1'b0, 16'sd1, 32'd2001, 1'b1, 1'b1);
      offer_block(1'b1, 16'sd1, 32'd2001, 1'b1, 1'b0);
      offer_block(1'b0, 16'sd1, 32'd2001, 1'b0, 1'b1);
      offer_block(1'b0, 16'sh7FFF, 32'hFFFF_FFFF, 1'b1, 1'b1);
      settle();

      // spare indexes, margin limit at max, then lower the window mid-window
      set_reg(CSR_SPARE_LO, 16'hFFFF);
      set_reg(CSR_SPARE_HI, 16'h0000);
      configure(16'd3, 16'd3, 16'd60, 16'd2, 1'b1, 16'sh7FFF);
      offer_block(1'b1, 16'sh7FFF, 32'hFFFF_FFFF, 1'b1, 1'b1);
      offer_block(1'b1, 16'sh7FFF, 32'hFFFF_FFFF, 1'b1, 1'b1);
      offer_block(1'b0, 16'sh7FFF, 32'hFFFF_FFFF, 1'b1, 1'b1);
      offer_block(1'b1, 16'sh7FFF, 32'hFFFF_FFFF, 1'b1, 1'b1);
      settle();
      set_reg(CSR_FALLBACK_WINDOW, 16'd2);
      csr_valid <= 1'b0;
      offer_block(1'b0, 16'sh8000, 32'd5000, 1'b1, 1'b1);
      offer_block(1'b1, 16'sh8000, 32'd5000, 1'b1, 1'b1);
      settle();

      // zero windows and zero limits, margin limit at min
      configure(16'd0, 16'd0, 16'd0, 16'd0, 1'b1, 16'sh8000);
      offer_block(1'b0, 16'sh8000, 32'd2001, 1'b1, 1'b1);
      offer_block(1'b0, 16'sh8001, 32'd2001, 1'b1, 1'b1);
      offer_block(1'b1, 16'sh8001, 32'd2001, 1'b1, 1'b0);
      offer_block(1'b1, 16'sd0, 32'd0, 1'b1, 1'b1);
      settle();

      // random phases, each with fresh settings, error rate and gap style
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         if ($urandom_range(0, 3) == 0)
            set_reg($urandom_range(0, 1) ? CSR_SPARE_HI : CSR_SPARE_LO, 16'($urandom));
         case ($urandom_range(0, 5))
            0:       ml = 16'sh8000;
            1:       ml = 16'sh7FFF;
            2:       ml = 16'sd0;
            default: ml = 16'($urandom);
         endcase
         configure(pick_window(), pick_limit(), pick_window(), pick_limit(),
                   1'($urandom_range(0, 3) != 0), ml);
         n         = $urandom_range(10, 60);
         err_thr   = err_levels[$urandom_range(0, 4)];
         gap_style = $urandom_range(0, 2);
         left      = n;
         while (left > 0) begin
            burst = $urandom_range(1, 16);
            if (burst > left) burst = left;
            repeat (burst) begin
               case ($urandom_range(0, 7))
                  0: mg = 16'sh8000;
                  1: mg = 16'sh7FFF;
                  2, 3: begin
                     mg_wide = int'(margin_ref) + int'($urandom_range(0, 4)) - 2;
                     if (mg_wide > 32767) mg_wide = 32767;
                     if (mg_wide < -32768) mg_wide = -32768;
                     mg = 16'(mg_wide);
                  end
                  default: mg = 16'($urandom);
               endcase
               case ($urandom_range(0, 7))
                  0:       cnt = 32'd0;
                  1:       cnt = 32'hFFFF_FFFF;
                  2, 3:    cnt = MIN_BLOCKS - 32'd5 + 32'($urandom_range(0, 10));
                  default: cnt = $urandom;
               endcase
               offer_block(1'($urandom_range(0, 15) < err_thr), mg, cnt,
                           1'($urandom_range(0, 3) != 0), 1'($urandom_range(0, 1)));
               left--;
            end
            case (gap_style)
               0:       gap = 0;
               1:       gap = $urandom_range(0, 3);
               default: gap = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40)
                                                          : $urandom_range(0, 4);
            endcase
            if (left == 0 || gap > 0) req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         settle();
         sent += n;
      end

      // let any stray result item show up
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && reports_waiting == 0)
         $display("link_rate_fallback_monitor_core test passed");
      else
         $display("link_rate_fallback_monitor_core test failed");
      $finish;
   end

   initial begin
      #(RUN_LIMIT);
      $display("link_rate_fallback_monitor_core test failed");
      $finish;
   end

endmodule
